@@ design/lcc_pkg.sv @@
// Package with the types, constants and helper functions of the Luhn card number check.
`default_nettype none

package lcc_pkg;

    localparam int MAX_DIGITS = 19;
    localparam int COUNT_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CLASS_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] LEN_SHORT   = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_MID     = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_LONG    = 5'd16;

    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_3X      = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_5X      = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_4X      = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } lcc_item_t;

    typedef struct packed {
        logic               valid_res;
        logic [CLASS_W-1:0] issuer_class;
        logic [COUNT_W-1:0] digit_total;
    } lcc_result_t;

    // Doubling step of the Luhn scheme: 2d, or 2d - 9 when that reaches ten.
    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        begin
            t = {d, 1'b0};
            if (t >= 5'd10)
            begin
                t = t - 5'd9;
            end
            luhn_double = t[DIGIT_W-1:0];
        end
    endfunction

    // Sum of two values below ten, reduced mod ten.
    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] t;
        begin
            t = {1'b0, a} + {1'b0, b};
            if (t >= 5'd10)
            begin
                t = t - 5'd10;
            end
            add_mod10 = t[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input logic [COUNT_W-1:0] total,
                                                    input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
        begin
            if (total < 5'd2)
            begin
                classify = CLASS_UNKNOWN;
            end
            else if (a == 4'd3 && (b == 4'd4 || b == 4'd7))
            begin
                classify = CLASS_3X;
            end
            else if (a == 4'd5 && b >= 4'd1 && b <= 4'd5)
            begin
                classify = CLASS_5X;
            end
            else if (a == 4'd4)
            begin
                classify = CLASS_4X;
            end
            else
            begin
                classify = CLASS_UNKNOWN;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ design/lcc_if.sv @@
// Handshake interfaces for the digit requests and the result requests.
`default_nettype none

interface lcc_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;
    logic       last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface lcc_result_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [1:0] issuer_class;
    logic [4:0] digit_total;

    modport source (output valid, output valid_res, output issuer_class, output digit_total,
                    input ready);
    modport sink   (input valid, input valid_res, input issuer_class, input digit_total,
                    output ready);
endinterface

`default_nettype wire

@@ design/lcc_luhn_acc.sv @@
// Running Luhn sums, digit count and prefix store, with the final verdict logic.
`default_nettype none

module lcc_luhn_acc
    import lcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire lcc_item_t   item,
    output lcc_result_t      res
);

    logic [DIGIT_W-1:0] even_acc_reg, even_acc_next;
    logic [DIGIT_W-1:0] odd_acc_reg, odd_acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DIGIT_W-1:0] first_reg, first_next;
    logic [DIGIT_W-1:0] second_reg, second_next;

    logic [DIGIT_W-1:0] d;
    logic [DIGIT_W-1:0] dd;
    logic [DIGIT_W-1:0] sel_sum;
    logic               len_ok;
    logic [CLASS_W-1:0] cls;

    always_comb
    begin
        d  = (item.digit > 4'd9) ? 4'd9 : item.digit;
        dd = luhn_double(d);

        even_acc_next = even_acc_reg;
        odd_acc_next  = odd_acc_reg;
        first_next    = first_reg;
        second_next   = second_reg;

        if (count_reg < DIGIT_LIMIT)
        begin
            if (!count_reg[0])
            begin
                even_acc_next = add_mod10(even_acc_reg, dd);
                odd_acc_next  = add_mod10(odd_acc_reg, d);
            end
            else
            begin
                even_acc_next = add_mod10(even_acc_reg, d);
                odd_acc_next  = add_mod10(odd_acc_reg, dd);
            end
            if (count_reg == 5'd0)
            begin
                first_next = d;
            end
            else if (count_reg == 5'd1)
            begin
                second_next = d;
            end
        end

        count_next = (count_reg < COUNT_MAX) ? count_reg + 5'd1 : count_reg;

        cls     = classify(count_next, first_next, second_next);
        sel_sum = count_next[0] ? odd_acc_next : even_acc_next;
        len_ok  = (count_next == LEN_SHORT) || (count_next == LEN_MID) ||
                  (count_next == LEN_LONG);

        res.valid_res    = len_ok && (cls != CLASS_UNKNOWN) && (sel_sum == 4'd0);
        res.issuer_class = cls;
        res.digit_total  = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_acc_reg <= '0;
            odd_acc_reg  <= '0;
            count_reg    <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
        end
        else if (step)
        begin
            if (item.last_digit)
            begin
                even_acc_reg <= '0;
                odd_acc_reg  <= '0;
                count_reg    <= '0;
                first_reg    <= '0;
                second_reg   <= '0;
            end
            else
            begin
                even_acc_reg <= even_acc_next;
                odd_acc_reg  <= odd_acc_next;
                count_reg    <= count_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/luhn_card_number_check.sv @@
// Top level of the Luhn card number check: input register, accumulator and result register.
// A final digit is held in the input register, and its result is captured in the result register.
// One digit per cycle is taken, except while a final digit waits on a stalled result.
// A final digit waits in the input register while the previous result is still stalled.
// Reset clears the sums, the digit count, the stored prefix and both valid flags.
`default_nettype none

module luhn_card_number_check
    import lcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lcc_digit_if.sink     digits,
    lcc_result_if.source  results
);

    logic        in_vld_reg;
    lcc_item_t   in_item_reg;
    logic        res_vld_reg;
    lcc_result_t res_reg;
    lcc_result_t acc_res;
    logic        out_free;
    logic        proceed;
    logic        in_take;

    assign out_free = !res_vld_reg || results.ready;
    assign proceed  = in_vld_reg && (!in_item_reg.last_digit || out_free);
    assign in_take  = digits.valid && digits.ready;

    assign digits.ready = !in_vld_reg || proceed;

    lcc_luhn_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proceed),
        .item  (in_item_reg),
        .res   (acc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (digits.ready)
        begin
            in_vld_reg <= digits.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.digit      <= digits.digit;
            in_item_reg.last_digit <= digits.last_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_vld_reg <= proceed && in_item_reg.last_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && proceed && in_item_reg.last_digit)
        begin
            res_reg <= acc_res;
        end
    end

    assign results.valid        = res_vld_reg;
    assign results.valid_res    = res_reg.valid_res;
    assign results.issuer_class = res_reg.issuer_class;
    assign results.digit_total  = res_reg.digit_total;

endmodule

`default_nettype wire

@@ design/lcc_checker.sv @@
// Port-level checker for the Luhn card number check, attached to the top level by bind.
`default_nettype none

module lcc_checker
    import lcc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               valid_res,
    input wire logic [CLASS_W-1:0] issuer_class,
    input wire logic [COUNT_W-1:0] digit_total
);

    // A stalled result keeps its place and its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res) &&
        $stable(issuer_class) && $stable(digit_total))
        else $error("stalled result changed");

    // Every result follows at least one digit.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_total != 5'd0)
        else $error("result with a digit count of zero");

    // A passing number has a known issuer and an accepted length.
    a_pass_rules: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> issuer_class != CLASS_UNKNOWN &&
        (digit_total == LEN_SHORT || digit_total == LEN_MID || digit_total == LEN_LONG))
        else $error("pass reported without issuer or length");

    // An issuer needs two prefix digits.
    a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && issuer_class != CLASS_UNKNOWN |-> digit_total >= 5'd2)
        else $error("issuer reported for a one-digit number");

endmodule

bind luhn_card_number_check lcc_checker u_lcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .valid_res    (results.valid_res),
    .issuer_class (results.issuer_class),
    .digit_total  (results.digit_total)
);

`default_nettype wire
